[hdl/fms_pkg.sv]
// Shared types, codes and constants for the flight mode sequencer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package fms_pkg;

    // Default widths for the top level parameters
    localparam int POS_WIDTH_DEF  = 24;
    localparam int TICK_WIDTH_DEF = 24;

    localparam int MODE_W     = 4;
    localparam int CMD_W      = 3;
    localparam int REQ_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DIST_W     = 17;
    localparam int TCFG_W     = 24;
    localparam int SQ_W       = 2 * DIST_W;
    localparam int SUM_W      = SQ_W + 2;

    // Result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    // Modes
    localparam logic [MODE_W-1:0] MODE_IDLE     = 4'd0;
    localparam logic [MODE_W-1:0] MODE_INIT     = 4'd1;
    localparam logic [MODE_W-1:0] MODE_DISARMED = 4'd2;
    localparam logic [MODE_W-1:0] MODE_ARMING   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_ARMED    = 4'd4;
    localparam logic [MODE_W-1:0] MODE_TAKEOFF  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_HOVER    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_MOVING   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_REACHED  = 4'd8;
    localparam logic [MODE_W-1:0] MODE_LANDING  = 4'd9;
    localparam logic [MODE_W-1:0] MODE_ERROR    = 4'd10;

    // Commands
    localparam logic [CMD_W-1:0] CMD_NONE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ARM     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DISARM  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TAKEOFF = 3'd3;
    localparam logic [CMD_W-1:0] CMD_HOVER   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LAND    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_GOTO    = 3'd6;

    // Request types
    localparam logic [REQ_W-1:0] REQ_TICK    = 4'd0;
    localparam logic [REQ_W-1:0] REQ_ODOM    = 4'd1;
    localparam logic [REQ_W-1:0] REQ_GOAL    = 4'd2;
    localparam logic [REQ_W-1:0] REQ_ARM     = 4'd3;
    localparam logic [REQ_W-1:0] REQ_TAKEOFF = 4'd4;
    localparam logic [REQ_W-1:0] REQ_HOVER   = 4'd5;
    localparam logic [REQ_W-1:0] REQ_LAND    = 4'd6;
    localparam logic [REQ_W-1:0] REQ_DISARM  = 4'd7;
    localparam logic [REQ_W-1:0] REQ_RESET   = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAKEOFF_ALT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_RADIUS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUND_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_TIMEOUT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_CONFIRM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TKOFF_TMO    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LAND_TMO     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD         = 3'd7;

    // Configuration reset values
    localparam logic [DIST_W-1:0] RST_TAKEOFF_ALT  = 17'd5000;
    localparam logic [DIST_W-1:0] RST_GOAL_RADIUS  = 17'd500;
    localparam logic [DIST_W-1:0] RST_GROUND_LEVEL = 17'd500;
    localparam logic [TCFG_W-1:0] RST_ARM_TIMEOUT  = 24'd1000;
    localparam logic [TCFG_W-1:0] RST_ARM_CONFIRM  = 24'd200;
    localparam logic [TCFG_W-1:0] RST_TKOFF_TMO    = 24'd2000;
    localparam logic [TCFG_W-1:0] RST_LAND_TMO     = 24'd2000;
    localparam logic [TCFG_W-1:0] RST_HOLD         = 24'd400;

    typedef struct packed {
        logic [DIST_W-1:0] takeoff_altitude_mm;
        logic [DIST_W-1:0] goal_radius_mm;
        logic [DIST_W-1:0] ground_level_mm;
        logic [TCFG_W-1:0] arm_timeout_ticks;
        logic [TCFG_W-1:0] arm_confirm_ticks;
        logic [TCFG_W-1:0] takeoff_timeout_ticks;
        logic [TCFG_W-1:0] landing_timeout_ticks;
        logic [TCFG_W-1:0] hold_ticks;
    } cfg_t;

    // What one step hands to the result queue
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CMD_W-1:0]  cmd0;
        logic [CMD_W-1:0]  cmd1;
        logic              pair;
        logic              accepted;
    } res_ctl_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CMD_W-1:0]  command;
        logic              accepted;
        logic              last;
    } res_entry_t;

    // Allowed transitions: bit t of entry f is set if mode f may go to mode t
    localparam logic [15:0] ALLOWED_TO [16] = '{
        16'h0002,
        16'h0404,
        16'h0409,
        16'h0414,
        16'h0424,
        16'h0640,
        16'h0680,
        16'h0740,
        16'h06C0,
        16'h0404,
        16'h0001,
        16'h0000,
        16'h0000,
        16'h0000,
        16'h0000,
        16'h0000
    };

    function automatic logic mode_allowed(input logic [MODE_W-1:0] from_mode,
                                          input logic [MODE_W-1:0] to_mode);
        logic [15:0] row;
        row = ALLOWED_TO[from_mode];
        return row[to_mode];
    endfunction

endpackage

`default_nettype wire

[hdl/fms_cfg_regs.sv]
// Configuration register file of the flight mode sequencer.
// Depends on fms_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module fms_cfg_regs
    import fms_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TAKEOFF_ALT:  cfg_next.takeoff_altitude_mm   = cfg_data[DIST_W-1:0];
                CFG_GOAL_RADIUS:  cfg_next.goal_radius_mm        = cfg_data[DIST_W-1:0];
                CFG_GROUND_LEVEL: cfg_next.ground_level_mm       = cfg_data[DIST_W-1:0];
                CFG_ARM_TIMEOUT:  cfg_next.arm_timeout_ticks     = cfg_data[TCFG_W-1:0];
                CFG_ARM_CONFIRM:  cfg_next.arm_confirm_ticks     = cfg_data[TCFG_W-1:0];
                CFG_TKOFF_TMO:    cfg_next.takeoff_timeout_ticks = cfg_data[TCFG_W-1:0];
                CFG_LAND_TMO:     cfg_next.landing_timeout_ticks = cfg_data[TCFG_W-1:0];
                CFG_HOLD:         cfg_next.hold_ticks            = cfg_data[TCFG_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.takeoff_altitude_mm   <= RST_TAKEOFF_ALT;
            cfg_reg.goal_radius_mm        <= RST_GOAL_RADIUS;
            cfg_reg.ground_level_mm       <= RST_GROUND_LEVEL;
            cfg_reg.arm_timeout_ticks     <= RST_ARM_TIMEOUT;
            cfg_reg.arm_confirm_ticks     <= RST_ARM_CONFIRM;
            cfg_reg.takeoff_timeout_ticks <= RST_TKOFF_TMO;
            cfg_reg.landing_timeout_ticks <= RST_LAND_TMO;
            cfg_reg.hold_ticks            <= RST_HOLD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[hdl/fms_goal_check.sv]
// Goal proximity test: squared distance against the squared goal radius.
// Depends on fms_pkg; takes registered per-axis distances from fms_core.
`timescale 1ns / 1ps
`default_nettype none

module fms_goal_check
    import fms_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
)
(
    input  wire logic [POS_WIDTH:0]  abs_x,
    input  wire logic [POS_WIDTH:0]  abs_y,
    input  wire logic [POS_WIDTH:0]  abs_z,
    input  wire logic [DIST_W-1:0]   radius,
    output logic                     close
);

    localparam int AW = POS_WIDTH + 1;

    logic [AW-1:0]    rad_ext;
    logic             over;
    logic [SQ_W-1:0]  sq_x;
    logic [SQ_W-1:0]  sq_y;
    logic [SQ_W-1:0]  sq_z;
    logic [SQ_W-1:0]  rad_sq;
    logic [SUM_W-1:0] sum_sq;

    assign rad_ext = AW'(radius);

    // any axis beyond the radius rules the goal out; the rest fit in DIST_W bits
    assign over = (abs_x > rad_ext) || (abs_y > rad_ext) || (abs_z > rad_ext);

    assign sq_x   = abs_x[DIST_W-1:0] * abs_x[DIST_W-1:0];
    assign sq_y   = abs_y[DIST_W-1:0] * abs_y[DIST_W-1:0];
    assign sq_z   = abs_z[DIST_W-1:0] * abs_z[DIST_W-1:0];
    assign rad_sq = radius * radius;
    assign sum_sq = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);

    assign close = !over && (sum_sq < SUM_W'(rad_sq));

endmodule

`default_nettype wire

[hdl/fms_res_queue.sv]
// Result queue: holds up to RQ_DEPTH result words, takes one or two per step.
// Depends on fms_pkg for res_ctl_t, res_entry_t and the command codes.
`timescale 1ns / 1ps
`default_nettype none

module fms_res_queue
    import fms_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    input  wire res_ctl_t                    push_ctl,
    input  wire logic signed [POS_WIDTH-1:0] push_tx,
    input  wire logic signed [POS_WIDTH-1:0] push_ty,
    input  wire logic signed [POS_WIDTH-1:0] push_tz,
    output logic                             room,
    output logic                             res_valid,
    input  wire logic                        res_stall,
    output logic [MODE_W-1:0]                mode,
    output logic [CMD_W-1:0]                 command,
    output logic signed [POS_WIDTH-1:0]      target_x,
    output logic signed [POS_WIDTH-1:0]      target_y,
    output logic signed [POS_WIDTH-1:0]      target_z,
    output logic                             accepted,
    output logic                             last
);

    res_entry_t                  ent_reg [RQ_DEPTH];
    logic signed [POS_WIDTH-1:0] tx_reg  [RQ_DEPTH];
    logic signed [POS_WIDTH-1:0] ty_reg  [RQ_DEPTH];
    logic signed [POS_WIDTH-1:0] tz_reg  [RQ_DEPTH];

    logic [RQ_PTR_W-1:0] wr_ptr_reg;
    logic [RQ_PTR_W-1:0] wr_ptr_next;
    logic [RQ_PTR_W-1:0] wr_ptr_1;
    logic [RQ_PTR_W-1:0] rd_ptr_reg;
    logic [RQ_PTR_W-1:0] rd_ptr_next;
    logic [RQ_CNT_W-1:0] count_reg;
    logic [RQ_CNT_W-1:0] count_next;
    logic [RQ_CNT_W-1:0] push_n;
    logic                pop;
    res_entry_t          ent0;
    res_entry_t          ent1;

    assign pop       = res_valid && !res_stall;
    assign res_valid = (count_reg != '0);
    assign room      = (count_reg <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign wr_ptr_1  = wr_ptr_reg + 1'b1;

    always_comb
    begin
        ent0.mode     = push_ctl.mode;
        ent0.command  = push_ctl.cmd0;
        ent0.accepted = push_ctl.accepted;
        ent0.last     = !push_ctl.pair;
        ent1.mode     = push_ctl.mode;
        ent1.command  = push_ctl.cmd1;
        ent1.accepted = push_ctl.accepted;
        ent1.last     = 1'b1;

        push_n = '0;
        if (push)
        begin
            push_n = push_ctl.pair ? RQ_CNT_W'(2) : RQ_CNT_W'(1);
        end
        count_next  = count_reg + push_n - RQ_CNT_W'(pop);
        wr_ptr_next = wr_ptr_reg + push_n[RQ_PTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + RQ_PTR_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // second word of a pair never carries a target
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= ent0;
            tx_reg[wr_ptr_reg]  <= push_tx;
            ty_reg[wr_ptr_reg]  <= push_ty;
            tz_reg[wr_ptr_reg]  <= push_tz;
            if (push_ctl.pair)
            begin
                ent_reg[wr_ptr_1] <= ent1;
                tx_reg[wr_ptr_1]  <= '0;
                ty_reg[wr_ptr_1]  <= '0;
                tz_reg[wr_ptr_1]  <= '0;
            end
        end
    end

    assign mode     = ent_reg[rd_ptr_reg].mode;
    assign command  = ent_reg[rd_ptr_reg].command;
    assign accepted = ent_reg[rd_ptr_reg].accepted;
    assign last     = ent_reg[rd_ptr_reg].last;
    assign target_x = tx_reg[rd_ptr_reg];
    assign target_y = ty_reg[rd_ptr_reg];
    assign target_z = tz_reg[rd_ptr_reg];

endmodule

`default_nettype wire

[hdl/fms_core.sv]
// Input register, sequencer state and the single-pass step logic.
// Depends on fms_pkg; uses fms_goal_check's result through the top level.
`timescale 1ns / 1ps
`default_nettype none

module fms_core
    import fms_pkg::*;
#(
    parameter int POS_WIDTH  = POS_WIDTH_DEF,
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire logic [REQ_W-1:0]            req_type,
    input  wire logic signed [POS_WIDTH-1:0] pos_x,
    input  wire logic signed [POS_WIDTH-1:0] pos_y,
    input  wire logic signed [POS_WIDTH-1:0] pos_z,
    input  wire logic                        ack_ok,
    input  wire cfg_t                        cfg,
    output logic [POS_WIDTH:0]               abs_x,
    output logic [POS_WIDTH:0]               abs_y,
    output logic [POS_WIDTH:0]               abs_z,
    input  wire logic                        goal_close,
    input  wire logic                        room,
    output logic                             push,
    output res_ctl_t                         push_ctl,
    output logic signed [POS_WIDTH-1:0]      push_tx,
    output logic signed [POS_WIDTH-1:0]      push_ty,
    output logic signed [POS_WIDTH-1:0]      push_tz
);

    localparam int ZW  = ((POS_WIDTH > DIST_W) ? POS_WIDTH : DIST_W) + 1;
    localparam int TCW = (TICK_WIDTH > TCFG_W) ? TICK_WIDTH : TCFG_W;

    // input register
    logic                        s1_valid_reg;
    logic [REQ_W-1:0]            s1_req_reg;
    logic signed [POS_WIDTH-1:0] s1_x_reg;
    logic signed [POS_WIDTH-1:0] s1_y_reg;
    logic signed [POS_WIDTH-1:0] s1_z_reg;
    logic                        s1_ack_reg;

    // sequencer state
    logic [MODE_W-1:0]           mode_reg;
    logic [MODE_W-1:0]           mode_next;
    logic [TICK_WIDTH-1:0]       ticks_reg;
    logic [TICK_WIDTH-1:0]       ticks_next;
    logic signed [POS_WIDTH-1:0] cur_x_reg, cur_y_reg, cur_z_reg;
    logic signed [POS_WIDTH-1:0] cur_x_next, cur_y_next, cur_z_next;
    logic signed [POS_WIDTH-1:0] goal_x_reg, goal_y_reg, goal_z_reg;
    logic signed [POS_WIDTH-1:0] goal_x_next, goal_y_next, goal_z_next;
    logic                        odom_valid_reg, odom_valid_next;
    logic                        goal_valid_reg, goal_valid_next;
    logic [POS_WIDTH:0]          abs_x_reg, abs_y_reg, abs_z_reg;

    logic                        load;
    logic                        fire;
    logic [TICK_WIDTH-1:0]       ticks_inc;
    logic [TCW-1:0]              ticks_cmp;
    logic signed [ZW-1:0]        z_ext;
    logic signed [ZW-1:0]        alt_ext;
    logic signed [ZW-1:0]        gnd_ext;
    logic                        want;
    logic [MODE_W-1:0]           want_mode;
    logic                        change;
    logic                        acc;
    logic                        tgt;
    logic [CMD_W-1:0]            cmd0;
    logic [CMD_W-1:0]            cmd1;
    logic                        pair;
    logic                        rst_try1;
    logic [MODE_W-1:0]           rst_mode1;

    function automatic logic [POS_WIDTH:0] abs_diff(
        input logic signed [POS_WIDTH-1:0] a,
        input logic signed [POS_WIDTH-1:0] b
    );
        logic [POS_WIDTH:0] d;
        d = {a[POS_WIDTH-1], a} - {b[POS_WIDTH-1], b};
        return d[POS_WIDTH] ? (~d + 1'b1) : d;
    endfunction

    assign fire      = s1_valid_reg && room;
    assign req_stall = s1_valid_reg && !room;
    assign load      = req_valid && !req_stall;

    assign ticks_inc = (&ticks_reg) ? ticks_reg : (ticks_reg + 1'b1);
    assign ticks_cmp = TCW'(ticks_inc);
    assign z_ext     = ZW'(cur_z_reg);
    assign alt_ext   = ZW'({1'b0, cfg.takeoff_altitude_mm});
    assign gnd_ext   = ZW'({1'b0, cfg.ground_level_mm});

    always_comb
    begin
        want            = 1'b0;
        want_mode       = mode_reg;
        acc             = 1'b0;
        tgt             = 1'b0;
        cmd0            = CMD_NONE;
        cmd1            = CMD_NONE;
        pair            = 1'b0;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        cur_z_next      = cur_z_reg;
        goal_x_next     = goal_x_reg;
        goal_y_next     = goal_y_reg;
        goal_z_next     = goal_z_reg;
        odom_valid_next = odom_valid_reg;
        goal_valid_next = goal_valid_reg;
        rst_try1        = 1'b0;
        rst_mode1       = mode_reg;

        unique case (s1_req_reg)
            REQ_TICK:
            begin
                unique case (mode_reg)
                    MODE_INIT:
                    begin
                        if (ticks_cmp > TCW'(cfg.hold_ticks))
                        begin
                            want      = 1'b1;
                            want_mode = MODE_DISARMED;
                        end
                    end
                    MODE_ARMING:
                    begin
                        if (ticks_cmp > TCW'(cfg.arm_timeout_ticks))
                        begin
                            want      = 1'b1;
                            want_mode = MODE_ERROR;
                        end
                        else if (ticks_cmp > TCW'(cfg.arm_confirm_ticks))
                        begin
                            want      = 1'b1;
                            want_mode = MODE_ARMED;
                        end
                    end
                    MODE_TAKEOFF:
                    begin
                        if (ticks_cmp > TCW'(cfg.takeoff_timeout_ticks))
                        begin
                            want      = 1'b1;
                            want_mode = MODE_ERROR;
                        end
                        else if (odom_valid_reg && (z_ext >= alt_ext))
                        begin
                            want      = 1'b1;
                            want_mode = MODE_HOVER;
                        end
                    end
                    MODE_HOVER:
                    begin
                        if (odom_valid_reg)
                        begin
                            cmd0 = CMD_HOVER;
                        end
                    end
                    MODE_MOVING:
                    begin
                        if (!goal_valid_reg || !odom_valid_reg)
                        begin
                            want      = 1'b1;
                            want_mode = MODE_HOVER;
                        end
                        else if (goal_close)
                        begin
                            want      = 1'b1;
                            want_mode = MODE_REACHED;
                        end
                        else
                        begin
                            cmd0 = CMD_GOTO;
                            tgt  = 1'b1;
                        end
                    end
                    MODE_REACHED:
                    begin
                        if (ticks_cmp > TCW'(cfg.hold_ticks))
                        begin
                            want      = 1'b1;
                            want_mode = MODE_HOVER;
                        end
                    end
                    MODE_LANDING:
                    begin
                        if (ticks_cmp > TCW'(cfg.landing_timeout_ticks))
                        begin
                            want      = 1'b1;
                            want_mode = MODE_ERROR;
                        end
                        else if (odom_valid_reg && (z_ext < gnd_ext))
                        begin
                            cmd0      = CMD_DISARM;
                            want      = 1'b1;
                            want_mode = MODE_DISARMED;
                        end
                    end
                    MODE_ERROR:
                    begin
                        if (odom_valid_reg && (z_ext > gnd_ext))
                        begin
                            cmd0 = CMD_LAND;
                        end
                    end
                    default:
                    begin
                        want = 1'b0;
                    end
                endcase
            end
            REQ_ODOM:
            begin
                cur_x_next      = s1_x_reg;
                cur_y_next      = s1_y_reg;
                cur_z_next      = s1_z_reg;
                odom_valid_next = 1'b1;
                acc             = 1'b1;
            end
            REQ_GOAL:
            begin
                if (mode_reg == MODE_HOVER)
                begin
                    goal_x_next     = s1_x_reg;
                    goal_y_next     = s1_y_reg;
                    goal_z_next     = s1_z_reg;
                    goal_valid_next = 1'b1;
                    want            = 1'b1;
                    want_mode       = MODE_MOVING;
                end
            end
            REQ_ARM:
            begin
                if (mode_reg == MODE_DISARMED)
                begin
                    cmd0      = CMD_ARM;
                    want      = s1_ack_reg;
                    want_mode = MODE_ARMING;
                end
            end
            REQ_TAKEOFF:
            begin
                if (mode_reg == MODE_ARMED)
                begin
                    cmd0      = CMD_TAKEOFF;
                    want      = s1_ack_reg;
                    want_mode = MODE_TAKEOFF;
                end
            end
            REQ_HOVER:
            begin
                if (mode_reg inside {MODE_MOVING, MODE_REACHED})
                begin
                    cmd0      = CMD_HOVER;
                    want      = s1_ack_reg;
                    want_mode = MODE_HOVER;
                end
            end
            REQ_LAND:
            begin
                if (mode_reg inside {MODE_HOVER, MODE_MOVING, MODE_REACHED})
                begin
                    cmd0      = CMD_LAND;
                    want      = s1_ack_reg;
                    want_mode = MODE_LANDING;
                end
            end
            REQ_DISARM:
            begin
                if (mode_reg == MODE_ARMED)
                begin
                    cmd0      = CMD_DISARM;
                    want      = s1_ack_reg;
                    want_mode = MODE_DISARMED;
                end
            end
            REQ_RESET:
            begin
                if (mode_reg != MODE_DISARMED && mode_reg != MODE_IDLE)
                begin
                    if (mode_reg inside {MODE_HOVER, MODE_MOVING, MODE_REACHED})
                    begin
                        cmd0 = CMD_LAND;
                        cmd1 = CMD_DISARM;
                        pair = 1'b1;
                    end
                    else
                    begin
                        cmd0 = CMD_DISARM;
                    end
                end
                // try idle, then initializing, each through the table
                rst_try1        = mode_allowed(mode_reg, MODE_IDLE);
                rst_mode1       = rst_try1 ? MODE_IDLE : mode_reg;
                want            = 1'b1;
                want_mode       = MODE_INIT;
                odom_valid_next = 1'b0;
                goal_valid_next = 1'b0;
            end
            default:
            begin
                want = 1'b0;
            end
        endcase

        change = want && mode_allowed(rst_mode1, want_mode);
        if (change)
        begin
            mode_next = want_mode;
        end
        else
        begin
            mode_next = rst_mode1;
        end
        change = change || rst_try1;

        if (s1_req_reg == REQ_RESET)
        begin
            acc = (mode_next == MODE_INIT);
        end
        else if (change)
        begin
            acc = 1'b1;
        end

        if (change)
        begin
            ticks_next = '0;
        end
        else if (s1_req_reg == REQ_TICK)
        begin
            ticks_next = ticks_inc;
        end
        else
        begin
            ticks_next = ticks_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_req_reg <= req_type;
            s1_x_reg   <= pos_x;
            s1_y_reg   <= pos_y;
            s1_z_reg   <= pos_z;
            s1_ack_reg <= ack_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_DISARMED;
            ticks_reg      <= '0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            cur_z_reg      <= '0;
            goal_x_reg     <= '0;
            goal_y_reg     <= '0;
            goal_z_reg     <= '0;
            odom_valid_reg <= 1'b0;
            goal_valid_reg <= 1'b0;
            abs_x_reg      <= '0;
            abs_y_reg      <= '0;
            abs_z_reg      <= '0;
        end
        else if (fire)
        begin
            mode_reg       <= mode_next;
            ticks_reg      <= ticks_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            cur_z_reg      <= cur_z_next;
            goal_x_reg     <= goal_x_next;
            goal_y_reg     <= goal_y_next;
            goal_z_reg     <= goal_z_next;
            odom_valid_reg <= odom_valid_next;
            goal_valid_reg <= goal_valid_next;
            // keep the per-axis distances ready for the next proximity test
            abs_x_reg      <= abs_diff(goal_x_next, cur_x_next);
            abs_y_reg      <= abs_diff(goal_y_next, cur_y_next);
            abs_z_reg      <= abs_diff(goal_z_next, cur_z_next);
        end
    end

    assign abs_x = abs_x_reg;
    assign abs_y = abs_y_reg;
    assign abs_z = abs_z_reg;

    assign push              = fire;
    assign push_ctl.mode     = mode_next;
    assign push_ctl.cmd0     = cmd0;
    assign push_ctl.cmd1     = cmd1;
    assign push_ctl.pair     = pair;
    assign push_ctl.accepted = acc;
    assign push_tx           = tgt ? goal_x_reg : '0;
    assign push_ty           = tgt ? goal_y_reg : '0;
    assign push_tz           = tgt ? goal_z_reg : '0;

endmodule

`default_nettype wire

[hdl/flight_mode_sequencer_top.sv]
// Top level of the flight mode sequencer: config registers, core, goal check
// and result queue. Depends on fms_pkg and the fms_* modules.
//
// Channel   Direction  Handshake             Payload
// request   in         req_valid/req_stall   req_type, pos_x/y/z, ack_ok
// result    out        res_valid/res_stall   mode, command, target_x/y/z, accepted, last
// config    in         cfg_we                cfg_index, cfg_data
//
// A request word is registered, then stepped through the mode logic and the
// three squarers of the goal check; one word per cycle enters while the queue
// has room. Each step pushes one or two result words into a four-word queue;
// the queue drains one word per cycle while res_stall is low.
// req_stall rises only while a registered request waits for queue room.
// Reset: mode disarmed, counters, positions and flags cleared, queue empty.
`timescale 1ns / 1ps
`default_nettype none

module flight_mode_sequencer_top
    import fms_pkg::*;
#(
    parameter int POS_WIDTH  = POS_WIDTH_DEF,
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire logic [REQ_W-1:0]            req_type,
    input  wire logic signed [POS_WIDTH-1:0] pos_x,
    input  wire logic signed [POS_WIDTH-1:0] pos_y,
    input  wire logic signed [POS_WIDTH-1:0] pos_z,
    input  wire logic                        ack_ok,
    output logic                             res_valid,
    input  wire logic                        res_stall,
    output logic [MODE_W-1:0]                mode,
    output logic [CMD_W-1:0]                 command,
    output logic signed [POS_WIDTH-1:0]      target_x,
    output logic signed [POS_WIDTH-1:0]      target_y,
    output logic signed [POS_WIDTH-1:0]      target_z,
    output logic                             accepted,
    output logic                             last,
    input  wire logic                        cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       cfg_data
);

    cfg_t                        cfg;
    logic [POS_WIDTH:0]          abs_x;
    logic [POS_WIDTH:0]          abs_y;
    logic [POS_WIDTH:0]          abs_z;
    logic                        goal_close;
    logic                        room;
    logic                        push;
    res_ctl_t                    push_ctl;
    logic signed [POS_WIDTH-1:0] push_tx;
    logic signed [POS_WIDTH-1:0] push_ty;
    logic signed [POS_WIDTH-1:0] push_tz;

    fms_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fms_core #(
        .POS_WIDTH  (POS_WIDTH),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .ack_ok     (ack_ok),
        .cfg        (cfg),
        .abs_x      (abs_x),
        .abs_y      (abs_y),
        .abs_z      (abs_z),
        .goal_close (goal_close),
        .room       (room),
        .push       (push),
        .push_ctl   (push_ctl),
        .push_tx    (push_tx),
        .push_ty    (push_ty),
        .push_tz    (push_tz)
    );

    fms_goal_check #(
        .POS_WIDTH (POS_WIDTH)
    ) u_goal
    (
        .abs_x  (abs_x),
        .abs_y  (abs_y),
        .abs_z  (abs_z),
        .radius (cfg.goal_radius_mm),
        .close  (goal_close)
    );

    fms_res_queue #(
        .POS_WIDTH (POS_WIDTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_ctl  (push_ctl),
        .push_tx   (push_tx),
        .push_ty   (push_ty),
        .push_tz   (push_tz),
        .room      (room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .mode      (mode),
        .command   (command),
        .target_x  (target_x),
        .target_y  (target_y),
        .target_z  (target_z),
        .accepted  (accepted),
        .last      (last)
    );

    // stall only while the queue cannot take a full step
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> !room)
        else $error("request stalled while queue has room");

    // the second word of a pair is queued with the first
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !last) |=> res_valid)
        else $error("first word of a pair not followed by its partner");

    // a target is only given with go to goal
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && command != CMD_GOTO) |->
            (target_x == '0 && target_y == '0 && target_z == '0))
        else $error("target present without go to goal");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (mode <= MODE_ERROR))
        else $error("result word carries an unreachable mode");

endmodule

`default_nettype wire
